@@ design/srmp_pkg.sv @@
// ----------------------------------------------------------------------------
// srmp_pkg: shared types and constants of the steering speed ramp.
// Mode codes, register indices, fixed field widths and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package srmp_pkg;

  // Fixed widths of the configuration registers and internal state.
  localparam int STEPS_W   = 10;              // ramp_steps
  localparam int MARGIN_W  = 15;              // both angle margins
  localparam int MAX_W     = 16;              // max_speed
  localparam int CNT_W     = 11;              // signed ramp counter
  localparam int K_W       = CNT_W + 1;       // signed (steps - counter)
  localparam int PROD_W    = MAX_W + K_W - 1; // max_speed * positive k
  localparam int DIVISOR_W = STEPS_W + 1;     // 2 * steps
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);
  localparam int MODE_W    = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 3'd0,
    MODE_SLOW  = 3'd1,
    MODE_FAST  = 3'd2,
    MODE_DECEL = 3'd3,
    MODE_ACCEL = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_RAMP_STEPS   = 2'd0,
    REG_DECEL_MARGIN = 2'd1,
    REG_ACCEL_MARGIN = 2'd2,
    REG_MAX_SPEED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

@@ design/steering_based_speed_ramp_unit.sv @@
// ----------------------------------------------------------------------------
// steering_based_speed_ramp_unit: speed command from steering angle.
// Start, slow and fast results skip the divider, as does a ramp whose figure
// is not positive; other ramp figures go through the 27-step serial divider.
// One request at a time: the next one is taken only after the last result
// has moved from S_DONE to the output register.
// Synchronous reset restores register defaults, start mode and idle control.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_based_speed_ramp_unit #(
  parameter int ANGLE_WIDTH = 16,
  parameter int SPEED_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input request channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [ANGLE_WIDTH-1:0]       steering_angle,
  // Result channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [SPEED_WIDTH-1:0]                   speed_command,
  output logic [srmp_pkg::MODE_W-1:0]              speed_mode,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srmp_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [srmp_pkg::DATA_W-1:0]         pwdata,
  output logic [srmp_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready
);

  // Width for the threshold compares: the larger of the angle magnitude
  // and the margins, plus one bit for the sum.
  localparam int MAG_W = ANGLE_WIDTH - 1;
  localparam int CMP_W = ((MAG_W > srmp_pkg::MARGIN_W) ? MAG_W : srmp_pkg::MARGIN_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers. The port always completes in the access cycle.
  // --------------------------------------------------------------------------
  logic [srmp_pkg::STEPS_W-1:0]  ramp_steps;
  logic [srmp_pkg::MARGIN_W-1:0] decel_angle_margin;
  logic [srmp_pkg::MARGIN_W-1:0] accel_angle_margin;
  logic [srmp_pkg::MAX_W-1:0]    max_speed;
  srmp_pkg::reg_idx_t            reg_idx;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = srmp_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_steps         <= srmp_pkg::STEPS_W'(10);
      decel_angle_margin <= srmp_pkg::MARGIN_W'(328);
      accel_angle_margin <= srmp_pkg::MARGIN_W'(410);
      max_speed          <= srmp_pkg::MAX_W'(1000);
    end else if (cfg_write) begin
      unique case (reg_idx)
        srmp_pkg::REG_RAMP_STEPS:   ramp_steps         <= pwdata[srmp_pkg::STEPS_W-1:0];
        srmp_pkg::REG_DECEL_MARGIN: decel_angle_margin <= pwdata[srmp_pkg::MARGIN_W-1:0];
        srmp_pkg::REG_ACCEL_MARGIN: accel_angle_margin <= pwdata[srmp_pkg::MARGIN_W-1:0];
        srmp_pkg::REG_MAX_SPEED:    max_speed          <= pwdata[srmp_pkg::MAX_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srmp_pkg::REG_RAMP_STEPS:   prdata = srmp_pkg::DATA_W'(ramp_steps);
      srmp_pkg::REG_DECEL_MARGIN: prdata = srmp_pkg::DATA_W'(decel_angle_margin);
      srmp_pkg::REG_ACCEL_MARGIN: prdata = srmp_pkg::DATA_W'(accel_angle_margin);
      srmp_pkg::REG_MAX_SPEED:    prdata = srmp_pkg::DATA_W'(max_speed);
    endcase
  end

  // --------------------------------------------------------------------------
  // Helper functions.
  // --------------------------------------------------------------------------

  // Magnitude of a signed angle; the most negative value saturates to the
  // largest positive magnitude.
  function automatic logic [MAG_W-1:0] sat_abs(input logic [ANGLE_WIDTH-1:0] v);
    logic [ANGLE_WIDTH-1:0] neg;
    neg = ~v + ANGLE_WIDTH'(1);
    if (!v[ANGLE_WIDTH-1]) begin
      return v[MAG_W-1:0];
    end
    if (neg[ANGLE_WIDTH-1]) begin
      return '1;
    end
    return neg[MAG_W-1:0];
  endfunction

  // Saturating counter steps; the counter stops at its signed limits.
  function automatic logic [srmp_pkg::CNT_W-1:0] cnt_inc(
    input logic [srmp_pkg::CNT_W-1:0] c
  );
    if (c == {1'b0, {(srmp_pkg::CNT_W-1){1'b1}}}) begin
      return c;
    end
    return c + srmp_pkg::CNT_W'(1);
  endfunction

  function automatic logic [srmp_pkg::CNT_W-1:0] cnt_dec(
    input logic [srmp_pkg::CNT_W-1:0] c
  );
    if (c == {1'b1, {(srmp_pkg::CNT_W-1){1'b0}}}) begin
      return c;
    end
    return c - srmp_pkg::CNT_W'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Mode state.
  // --------------------------------------------------------------------------
  srmp_pkg::mode_t                mode;
  logic [srmp_pkg::CNT_W-1:0]     ramp_counter;   // two's complement
  logic                           ramp_active;
  logic [ANGLE_WIDTH-1:0]         reference_angle;

  srmp_pkg::mode_t                mode_next;
  logic [srmp_pkg::CNT_W-1:0]     ramp_counter_next;
  logic                           ramp_active_next;
  logic [ANGLE_WIDTH-1:0]         reference_angle_next;

  // A ramp_steps value of zero behaves as one in all ramp arithmetic.
  logic [srmp_pkg::STEPS_W-1:0]   steps_eff;
  logic [srmp_pkg::CNT_W-1:0]     abs_cnt;

  srmp_pkg::mode_t                p1_mode;
  logic [srmp_pkg::CNT_W-1:0]     p1_cnt;
  logic                           p1_active;

  logic [CMP_W-1:0]               a_mag;
  logic [CMP_W-1:0]               r_mag;
  logic [CMP_W-1:0]               am_ext;
  logic [CMP_W-1:0]               up_thr;
  logic [CMP_W-1:0]               down_thr;
  logic                           rise;
  logic                           drop;

  assign steps_eff = (ramp_steps == '0) ? srmp_pkg::STEPS_W'(1) : ramp_steps;
  assign abs_cnt   = ramp_counter[srmp_pkg::CNT_W-1] ?
                     (~ramp_counter + srmp_pkg::CNT_W'(1)) : ramp_counter;

  // First the running ramp either finishes or takes one more step.
  always_comb begin
    p1_mode   = mode;
    p1_cnt    = ramp_counter;
    p1_active = ramp_active;
    if (ramp_active) begin
      if (abs_cnt >= {1'b0, steps_eff}) begin
        p1_active = 1'b0;
        if (mode == srmp_pkg::MODE_DECEL) begin
          p1_mode = srmp_pkg::MODE_SLOW;
        end else if (mode == srmp_pkg::MODE_ACCEL) begin
          p1_mode = srmp_pkg::MODE_FAST;
        end
      end else if (mode == srmp_pkg::MODE_DECEL) begin
        p1_cnt = cnt_inc(ramp_counter);
      end else if (mode == srmp_pkg::MODE_ACCEL) begin
        p1_cnt = cnt_dec(ramp_counter);
      end
    end
  end

  // Then the angle magnitude is checked against the two thresholds around
  // the stored reference angle. The lower threshold folds at zero.
  assign a_mag    = CMP_W'(sat_abs(steering_angle));
  assign r_mag    = CMP_W'(sat_abs(reference_angle));
  assign am_ext   = CMP_W'(accel_angle_margin);
  assign up_thr   = r_mag + CMP_W'(decel_angle_margin);
  assign down_thr = (r_mag >= am_ext) ? (r_mag - am_ext) : (am_ext - r_mag);
  assign rise     = a_mag > up_thr;
  assign drop     = !rise && (a_mag < down_thr);

  // Leaving start mode resets the counter but leaves the ramp flag alone,
  // so the first ramp out of start does not advance until a later trigger.
  always_comb begin
    mode_next            = p1_mode;
    ramp_counter_next    = p1_cnt;
    ramp_active_next     = p1_active;
    reference_angle_next = reference_angle;
    if (rise) begin
      if (p1_mode != srmp_pkg::MODE_SLOW && p1_mode != srmp_pkg::MODE_DECEL) begin
        if (p1_mode == srmp_pkg::MODE_START) begin
          ramp_counter_next = '0;
        end else begin
          ramp_counter_next = cnt_inc(p1_cnt);
          ramp_active_next  = 1'b1;
        end
        mode_next = srmp_pkg::MODE_DECEL;
      end
      reference_angle_next = steering_angle;
    end else if (drop) begin
      if (p1_mode != srmp_pkg::MODE_FAST && p1_mode != srmp_pkg::MODE_ACCEL) begin
        if (p1_mode == srmp_pkg::MODE_START) begin
          ramp_counter_next = '0;
        end else begin
          ramp_counter_next = cnt_dec(p1_cnt);
          ramp_active_next  = 1'b1;
        end
        mode_next = srmp_pkg::MODE_ACCEL;
      end
      reference_angle_next = steering_angle;
    end
  end

  // --------------------------------------------------------------------------
  // Speed command. Fixed modes give their value at once. A ramp computes
  // max_speed * (steps - counter) / (2 * steps): one multiply feeds the
  // serial divider, and a non-positive numerator short-cuts to zero.
  // --------------------------------------------------------------------------
  logic [srmp_pkg::K_W-1:0]       k_val;
  logic                           k_pos;
  logic                           need_div;
  logic [srmp_pkg::MAX_W-1:0]     direct_speed;

  assign k_val = {2'b00, steps_eff} -
                 {ramp_counter_next[srmp_pkg::CNT_W-1], ramp_counter_next};
  assign k_pos = !k_val[srmp_pkg::K_W-1] && (k_val != '0);
  assign need_div = k_pos && (mode_next == srmp_pkg::MODE_DECEL ||
                              mode_next == srmp_pkg::MODE_ACCEL);

  always_comb begin
    unique case (mode_next)
      srmp_pkg::MODE_START: direct_speed = {1'b0, max_speed[srmp_pkg::MAX_W-1:1]};
      srmp_pkg::MODE_FAST:  direct_speed = max_speed;
      srmp_pkg::MODE_SLOW,
      srmp_pkg::MODE_DECEL,
      srmp_pkg::MODE_ACCEL: direct_speed = '0;
      default:              direct_speed = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer. Idle takes a request and updates the mode state in the same
  // cycle; a ramp with a positive numerator then goes through multiply and
  // divide; the result waits in S_DONE until the output register is free.
  // --------------------------------------------------------------------------
  state_t                         state;
  state_t                         state_next;
  logic                           in_accept;
  logic                           out_load;
  logic [srmp_pkg::K_W-2:0]       res_k;
  logic [srmp_pkg::MAX_W-1:0]     res_speed;
  srmp_pkg::mode_t                res_mode;
  logic [srmp_pkg::PROD_W-1:0]    product;
  logic [srmp_pkg::DIVISOR_W-1:0] divisor;
  logic                           div_start;
  srmp_pkg::div_status_t          div_status;
  logic [srmp_pkg::PROD_W-1:0]    quotient;
  logic [srmp_pkg::MAX_W-1:0]     ramp_speed;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign div_start = (state == S_MUL);
  assign product   = srmp_pkg::PROD_W'(max_speed) * srmp_pkg::PROD_W'(res_k);
  assign divisor   = {steps_eff, 1'b0};

  // A ramp command above max_speed clamps to it (possible after ramp_steps
  // shrinks during a ramp).
  assign ramp_speed = (quotient > srmp_pkg::PROD_W'(max_speed)) ? max_speed
                      : quotient[srmp_pkg::MAX_W-1:0];

  srmp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (divisor),
    .status   (div_status),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = need_div ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      mode            <= srmp_pkg::MODE_START;
      ramp_counter    <= '0;
      ramp_active     <= 1'b0;
      reference_angle <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        mode            <= mode_next;
        ramp_counter    <= ramp_counter_next;
        ramp_active     <= ramp_active_next;
        reference_angle <= reference_angle_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_k     <= k_val[srmp_pkg::K_W-2:0];
      res_mode  <= mode_next;
      res_speed <= direct_speed;
    end else if (state == S_DIV && div_status.done) begin
      res_speed <= ramp_speed;
    end
    if (out_load) begin
      speed_command <= SPEED_WIDTH'(res_speed);
      speed_mode    <= res_mode;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_ramp_flag_mode: assert property (@(posedge clk) disable iff (rst)
    ramp_active |-> (mode == srmp_pkg::MODE_DECEL || mode == srmp_pkg::MODE_ACCEL))
    else $error("ramp flag set outside a ramp mode");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    (div_status.busy || div_status.done) |-> (state == S_DIV))
    else $error("divider active outside the divide state");

  a_slow_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && speed_mode == srmp_pkg::MODE_SLOW) |-> (speed_command == '0))
    else $error("slow mode result with nonzero speed");

  a_fast_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && speed_mode == srmp_pkg::MODE_FAST) |->
      (speed_command == SPEED_WIDTH'(max_speed)))
    else $error("fast mode result differs from full speed");

endmodule

`default_nettype wire

@@ design/srmp_div.sv @@
// ----------------------------------------------------------------------------
// srmp_div: serial restoring divider.
// Produces one quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
`default_nettype none

module srmp_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [srmp_pkg::PROD_W-1:0]    dividend,
  input  wire logic [srmp_pkg::DIVISOR_W-1:0] divisor,
  output srmp_pkg::div_status_t               status,
  output logic [srmp_pkg::PROD_W-1:0]         quotient
);

  logic [srmp_pkg::DIVISOR_W-1:0] rem;
  logic [srmp_pkg::DIV_CNT_W-1:0] count;
  logic                           busy;
  logic                           done;
  logic [srmp_pkg::DIVISOR_W:0]   trial;
  logic [srmp_pkg::DIVISOR_W:0]   trial_diff;
  logic                           fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial      = {rem, quotient[srmp_pkg::PROD_W-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= srmp_pkg::DIV_CNT_W'(srmp_pkg::PROD_W);
      end else if (busy) begin
        count <= count - srmp_pkg::DIV_CNT_W'(1);
        if (count == srmp_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial_diff[srmp_pkg::DIVISOR_W-1:0]
                       : trial[srmp_pkg::DIVISOR_W-1:0];
      quotient <= {quotient[srmp_pkg::PROD_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire
